// File: design/jpdz_pkg.sv
`timescale 1ns / 1ps

package jpdz_pkg;

  // CORDIC datapath widths. X and Y carry the Q1.15 axes shifted left by 8 and
  // must hold the gain-grown magnitude. Z is the angle in units of 2^-16 degree.
  localparam int XW = 27;
  localparam int ZW = 26;

  localparam int AXIS_W = 16;
  localparam int LIMIT_W = 15;
  localparam int HEADING_W = 16;
  localparam int MAG_W = 16;

  localparam int ATAN_LEN = 24;
  localparam int ATAN_W = 22;

  // round(atan(2^-i) * 180/pi * 65536)
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  localparam logic signed [ZW-1:0] ANGLE_180 = 26'sd11796480;

  localparam logic [LIMIT_W-1:0] DZ_LIMIT_RESET = 15'd3932;

  // Angle to hundredths: (z * 100 + 2^15) >> 16.
  localparam int ANG_PROD_W = ZW + 8;
  localparam logic signed [ANG_PROD_W-1:0] ANG_SCALE = 34'sd100;
  localparam logic signed [ANG_PROD_W-1:0] ANG_ROUND = 34'sd32768;

  // Magnitude: (x * 39797 + 2^23) >> 24, 39797 undoing the CORDIC gain.
  localparam int MAG_PROD_W = XW + 17;
  localparam logic signed [MAG_PROD_W-1:0] GAIN_INV = 44'sd39797;
  localparam logic signed [MAG_PROD_W-1:0] MAG_ROUND = 44'sd8388608;

  localparam logic signed [17:0] ANG_MAX = 18'sd18000;
  localparam logic signed [17:0] ANG_MIN = -18'sd18000;
  localparam logic signed [17:0] ANG_WRAP = -18'sd9000;
  localparam logic signed [17:0] OFS_WRAP = 18'sd27000;
  localparam logic signed [17:0] OFS_FWD = 18'sd9000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic signed [HEADING_W-1:0] heading;
    logic [MAG_W-1:0]            magnitude;
  } polar_t;

endpackage

// File: design/jpdz_pre.sv
`timescale 1ns / 1ps

module jpdz_pre (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load_i,
  input  logic signed [jpdz_pkg::AXIS_W-1:0] axis_x_i,
  input  logic signed [jpdz_pkg::AXIS_W-1:0] axis_y_i,
  input  logic [jpdz_pkg::LIMIT_W-1:0]      limit_i,
  output logic                              vld_o,
  output jpdz_pkg::cordic_vec_t             vec_o,
  output logic                              dz_o
);
  import jpdz_pkg::*;

  logic                  vld_r;
  cordic_vec_t           vec_r, vec_nxt;
  logic                  dz_r, dz_nxt;
  logic [AXIS_W:0]       abs_x, abs_y;
  logic signed [XW-1:0]  ax, ay;
  logic                  x_neg;

  // |x| equals |axis_x| since x is the negated axis.
  assign abs_x = axis_x_i[AXIS_W-1] ? (17'd0 - {1'b1, axis_x_i}) : {1'b0, axis_x_i};
  assign abs_y = axis_y_i[AXIS_W-1] ? (17'd0 - {1'b1, axis_y_i}) : {1'b0, axis_y_i};
  assign dz_nxt = (abs_x <= {2'b00, limit_i}) && (abs_y <= {2'b00, limit_i});

  assign ax = {{(XW-AXIS_W-8){axis_x_i[AXIS_W-1]}}, axis_x_i, 8'd0};
  assign ay = {{(XW-AXIS_W-8){axis_y_i[AXIS_W-1]}}, axis_y_i, 8'd0};

  // The negated x is below zero when the raw axis is positive.
  assign x_neg = !axis_x_i[AXIS_W-1] && (axis_x_i != '0);

  // A vector in the left half plane is turned by 180 degrees first.
  always_comb begin
    if (x_neg) begin
      vec_nxt.x = ax;
      vec_nxt.y = -ay;
      vec_nxt.z = axis_y_i[AXIS_W-1] ? -ANGLE_180 : ANGLE_180;
    end else begin
      vec_nxt.x = -ax;
      vec_nxt.y = ay;
      vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      vec_r <= vec_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;
  assign dz_o  = dz_r;

endmodule

// File: design/jpdz_cell.sv
`timescale 1ns / 1ps

module jpdz_cell #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  jpdz_pkg::cordic_vec_t vec_i,
  output logic                  vld_o,
  output jpdz_pkg::cordic_vec_t vec_o
);
  import jpdz_pkg::*;

  logic                  vld_r;
  cordic_vec_t           vec_r, vec_nxt;
  logic signed [XW-1:0]  x_in, y_in, dx, dy;
  logic signed [ZW-1:0]  z_in, ang;

  assign x_in = vec_i.x;
  assign y_in = vec_i.y;
  assign z_in = vec_i.z;
  assign dx   = y_in >>> STAGE;
  assign dy   = x_in >>> STAGE;
  assign ang  = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_TABLE[STAGE]});

  // Rotate toward the x axis; both updates use the incoming x and y.
  always_comb begin
    if (!y_in[XW-1]) begin
      vec_nxt.x = x_in + dx;
      vec_nxt.y = y_in - dy;
      vec_nxt.z = z_in + ang;
    end else begin
      vec_nxt.x = x_in - dx;
      vec_nxt.y = y_in + dy;
      vec_nxt.z = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;

endmodule

// File: design/jpdz_post.sv
`timescale 1ns / 1ps

module jpdz_post (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  jpdz_pkg::cordic_vec_t vec_i,
  input  logic                  take_i,
  output logic                  vld_o,
  output jpdz_pkg::polar_t      res_o
);
  import jpdz_pkg::*;

  logic                         prod_vld_r;
  logic                         res_vld_r, res_vld_nxt;
  logic signed [ANG_PROD_W-1:0] ang_prod_r, ang_prod_nxt;
  logic signed [MAG_PROD_W-1:0] mag_prod_r, mag_prod_nxt;
  logic signed [17:0]           ang_full, ang_sat, head_full;
  logic signed [19:0]           mag_full;
  polar_t                       res_r, res_nxt;

  assign ang_prod_nxt = {{(ANG_PROD_W-ZW){vec_i.z[ZW-1]}}, vec_i.z} * ANG_SCALE + ANG_ROUND;
  assign mag_prod_nxt = {{(MAG_PROD_W-XW){vec_i.x[XW-1]}}, vec_i.x} * GAIN_INV + MAG_ROUND;

  assign ang_full = ang_prod_r[ANG_PROD_W-1:16];
  assign mag_full = mag_prod_r[MAG_PROD_W-1:24];

  always_comb begin
    if (ang_full > ANG_MAX) begin
      ang_sat = ANG_MAX;
    end else if (ang_full < ANG_MIN) begin
      ang_sat = ANG_MIN;
    end else begin
      ang_sat = ang_full;
    end

    // Turn the math angle into a heading with forward at zero and right positive.
    if (ang_sat <= ANG_WRAP) begin
      head_full = -ang_sat - OFS_WRAP;
    end else begin
      head_full = -ang_sat + OFS_FWD;
    end
    res_nxt.heading = head_full[HEADING_W-1:0];

    if (mag_full[19]) begin
      res_nxt.magnitude = '0;
    end else if (mag_full[19:MAG_W] != '0) begin
      res_nxt.magnitude = '1;
    end else begin
      res_nxt.magnitude = mag_full[MAG_W-1:0];
    end
  end

  // The result stays here until the top level moves it to the output register.
  always_comb begin
    if (prod_vld_r) begin
      res_vld_nxt = 1'b1;
    end else if (take_i) begin
      res_vld_nxt = 1'b0;
    end else begin
      res_vld_nxt = res_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      prod_vld_r <= vld_i;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_prod_r <= ang_prod_nxt;
    mag_prod_r <= mag_prod_nxt;
    if (prod_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = res_vld_r;
  assign res_o = res_r;

endmodule

// File: design/joystick_polar_with_dead_zone.sv
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// in_       in_valid/in_stall   in_axis_x, in_axis_y
// out_      out_valid/out_stall out_heading, out_magnitude, out_in_dead_zone
// cfg_      cfg_wr_en           cfg_wr_data (dead-zone limit)
//
// out_valid rises once an accepted item has passed the input stage, which loads at
// the accepting edge, then each CORDIC cell, two scaling stages and the output
// register. One item is in the cell chain at a time; in_stall drops once its
// result has moved to the output register (which out_stall can delay), and the
// next item can then overlap that result while it waits in the output register.
// Reset clears all valid flags, the held heading and loads the default limit.
// out_stall only holds the output register and, behind it, the next result.
module joystick_polar_with_dead_zone #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [jpdz_pkg::AXIS_W-1:0]   in_axis_x,
  input  logic signed [jpdz_pkg::AXIS_W-1:0]   in_axis_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jpdz_pkg::HEADING_W-1:0] out_heading,
  output logic [jpdz_pkg::MAG_W-1:0]           out_magnitude,
  output logic                                 out_in_dead_zone,
  input  logic                                 cfg_wr_en,
  input  logic [jpdz_pkg::LIMIT_W-1:0]         cfg_wr_data
);
  import jpdz_pkg::*;

  logic [LIMIT_W-1:0]          limit_r;
  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [HEADING_W-1:0] held_r;
  logic signed [HEADING_W-1:0] out_heading_r;
  logic [MAG_W-1:0]            out_magnitude_r;
  logic                        out_dz_r;
  logic                        accept, take, dz;
  logic                        post_vld;
  polar_t                      post_res;
  logic [CORDIC_STEPS:0]       stage_vld;
  cordic_vec_t                 stage_vec [CORDIC_STEPS+1];

  assign accept = in_valid && !busy_r;
  assign take   = post_vld && (!out_valid_r || !out_stall);

  jpdz_pre u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (accept),
    .axis_x_i (in_axis_x),
    .axis_y_i (in_axis_y),
    .limit_i  (limit_r),
    .vld_o    (stage_vld[0]),
    .vec_o    (stage_vec[0]),
    .dz_o     (dz)
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    jpdz_cell #(
      .STAGE (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (stage_vld[k]),
      .vec_i (stage_vec[k]),
      .vld_o (stage_vld[k+1]),
      .vec_o (stage_vec[k+1])
    );
  end

  jpdz_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (stage_vld[CORDIC_STEPS]),
    .vec_i  (stage_vec[CORDIC_STEPS]),
    .take_i (take),
    .vld_o  (post_vld),
    .res_o  (post_res)
  );

  always_comb begin
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (take) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= DZ_LIMIT_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (take && !dz) begin
        held_r <= post_res.heading;
      end
    end
  end

  // In the dead zone the last good heading is repeated with zero length.
  always_ff @(posedge clk) begin
    if (take) begin
      out_heading_r   <= dz ? held_r : post_res.heading;
      out_magnitude_r <= dz ? '0 : post_res.magnitude;
      out_dz_r        <= dz;
    end
  end

  assign in_stall         = busy_r;
  assign out_valid        = out_valid_r;
  assign out_heading      = out_heading_r;
  assign out_magnitude    = out_magnitude_r;
  assign out_in_dead_zone = out_dz_r;

  a_one_in_chain : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({stage_vld, post_vld}))
    else $error("more than one item in the cell chain");

  a_idle_chain : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (stage_vld == '0) && !post_vld)
    else $error("cell chain active while not busy");

  a_dz_zero_mag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_dead_zone |-> out_magnitude == '0)
    else $error("nonzero magnitude in dead zone");

  a_heading_range : assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_heading >= -16'sd18000) && (out_heading <= 16'sd18000))
    else $error("heading out of range");

endmodule
